// ===== rtl/core/mtsl_pkg.sv =====
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared types and constants for the two-list merge unit: the command codes
// of an input item and the element width.
// ----------------------------------------------------------------------------
`default_nettype none

package mtsl_pkg;

  // element width of both lists and of the merged output
  localparam int unsigned ValueWidth = 32;

  // command field width
  localparam int unsigned CmdWidth = 2;

  // input item commands; the fourth code is unused and ignored
  typedef enum logic [CmdWidth-1:0] {
    CMD_APPEND_ONE = 2'd0,
    CMD_APPEND_TWO = 2'd1,
    CMD_FINISH     = 2'd2
  } cmd_e;

endpackage

`default_nettype wire

// ===== rtl/core/merge_two_sorted_lists_unit.sv =====
// ----------------------------------------------------------------------------
// merge_two_sorted_lists_unit
// Collects two ascending lists of signed values and, on a finish item, emits
// their two-way merge one element per cycle, ties taken from list one first.
// ----------------------------------------------------------------------------
//
// Channel   Ports                                   Handshake
// --------  --------------------------------------  ---------------------------
// command   start_i, busy_o, cmd_i, value_i         taken when start_i && !busy_o
// result    res_valid_o, value_res_o, last_o,       one-cycle strobe, no stall
//           dropped_o
//
// An append item leaves busy_o low, so appends can come back to back. A
// finish item with N stored elements holds busy_o high for N compares of
// the two list heads in the shared comparator; results come one per cycle
// through the result registers, the first after the state register enters
// the merge state. A finish with both lists empty emits nothing. Reset
// empties both lists and clears the drop flag; the list memories
// themselves are not cleared. The receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_two_sorted_lists_unit #(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  output logic                                       busy_o,
  input  wire logic [mtsl_pkg::CmdWidth-1:0]         cmd_i,
  input  wire logic signed [mtsl_pkg::ValueWidth-1:0] value_i,
  output logic                                       res_valid_o,
  output logic signed [mtsl_pkg::ValueWidth-1:0]     value_res_o,
  output logic                                       last_o,
  output logic                                       dropped_o
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] DepthCnt = CW'(LIST_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0] cnt1_q, cnt1_d, cnt2_q, cnt2_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [CW-1:0] i_nx, j_nx;
  logic          drop_q, drop_d;

  logic                                res_valid_d, last_d;
  logic [mtsl_pkg::ValueWidth-1:0]     value_res_d;
  logic [mtsl_pkg::ValueWidth-1:0]     mem1 [LIST_DEPTH];
  logic [mtsl_pkg::ValueWidth-1:0]     mem2 [LIST_DEPTH];
  logic [mtsl_pkg::ValueWidth-1:0]     head1_q, head2_q;

  logic           accept;
  mtsl_pkg::cmd_e cmd;
  logic           wr1, wr2;
  logic           ok1, ok2, take1, fin;

  assign accept = start_i && !busy_o;
  assign cmd    = mtsl_pkg::cmd_e'(cmd_i);
  assign busy_o = (state_q != ST_IDLE);

  // head compare: the one shared comparator
  assign ok1   = (i_q < cnt1_q);
  assign ok2   = (j_q < cnt2_q);
  assign take1 = ok1 && (!ok2 || ($signed(head1_q) <= $signed(head2_q)));
  assign i_nx  = i_q + CW'(take1);
  assign j_nx  = j_q + CW'(!take1);
  assign fin   = (i_nx == cnt1_q) && (j_nx == cnt2_q);

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    cnt1_d      = cnt1_q;
    cnt2_d      = cnt2_q;
    i_d         = i_q;
    j_d         = j_q;
    drop_d      = drop_q;
    res_valid_d = 1'b0;
    value_res_d = take1 ? head1_q : head2_q;
    last_d      = fin;
    wr1         = 1'b0;
    wr2         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            mtsl_pkg::CMD_APPEND_ONE: begin
              if (cnt1_q == DepthCnt) begin
                drop_d = 1'b1;
              end else begin
                wr1    = 1'b1;
                cnt1_d = cnt1_q + CW'(1);
              end
            end
            mtsl_pkg::CMD_APPEND_TWO: begin
              if (cnt2_q == DepthCnt) begin
                drop_d = 1'b1;
              end else begin
                wr2    = 1'b1;
                cnt2_d = cnt2_q + CW'(1);
              end
            end
            mtsl_pkg::CMD_FINISH: begin
              if (cnt1_q == '0 && cnt2_q == '0) begin
                drop_d = 1'b0;
              end else begin
                state_d = ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        res_valid_d = 1'b1;
        if (fin) begin
          state_d = ST_IDLE;
          cnt1_d  = '0;
          cnt2_d  = '0;
          i_d     = '0;
          j_d     = '0;
          drop_d  = 1'b0;
        end else begin
          i_d = i_nx;
          j_d = j_nx;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt1_q      <= '0;
      cnt2_q      <= '0;
      i_q         <= '0;
      j_q         <= '0;
      drop_q      <= 1'b0;
      res_valid_o <= 1'b0;
      value_res_o <= '0;
      last_o      <= 1'b0;
      dropped_o   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt1_q      <= cnt1_d;
      cnt2_q      <= cnt2_d;
      i_q         <= i_d;
      j_q         <= j_d;
      drop_q      <= drop_d;
      res_valid_o <= res_valid_d;
      value_res_o <= value_res_d;
      last_o      <= last_d;
      dropped_o   <= drop_q;
    end
  end

  // list memories: write at the fill count, read the next head index
  always_ff @(posedge clk_i) begin
    if (wr1) begin
      mem1[cnt1_q[AW-1:0]] <= value_i;
    end
    if (wr2) begin
      mem2[cnt2_q[AW-1:0]] <= value_i;
    end
    head1_q <= mem1[i_d[AW-1:0]];
    head2_q <= mem2[j_d[AW-1:0]];
  end

`ifndef SYNTHESIS
  // the final result leaves both lists empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_o) |-> (cnt1_q == '0 && cnt2_q == '0 && !busy_o))
    else $error("lists not emptied after last result");

  // results only come out of a merge pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy_o))
    else $error("result without merge pass");

  // fill counts never pass the list depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt1_q <= DepthCnt) && (cnt2_q <= DepthCnt))
    else $error("list count overflow");

  // head indexes rest at zero between merges
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> (i_q == '0 && j_q == '0))
    else $error("head index not cleared");
`endif

endmodule

`default_nettype wire
